// ===== rtl/arprr_pkg.sv =====
// Package for the ARP resolver and responder: beat types, table write
// request, action codes, EtherType and ARP operation constants. No dependencies.
package arprr_pkg;

   localparam int unsigned TableEntries = 256;
   localparam int unsigned SlotW        = $clog2(TableEntries);
   localparam int unsigned MacW         = 48;
   localparam int unsigned IpW          = 32;
   localparam int unsigned CsrIdxW      = 1;

   localparam logic [2:0] ACT_NONE       = 3'd0;
   localparam logic [2:0] ACT_SEND_IP    = 3'd1;
   localparam logic [2:0] ACT_SEND_REQ   = 3'd2;
   localparam logic [2:0] ACT_SEND_REPLY = 3'd3;
   localparam logic [2:0] ACT_DELIVER    = 3'd4;

   localparam logic OPC_TRANSMIT = 1'b0;
   localparam logic OPC_RECEIVE  = 1'b1;

   localparam logic [15:0] ETH_ARP      = 16'h0806;
   localparam logic [15:0] ETH_IPV4     = 16'h0800;
   localparam logic [15:0] ARP_OPER_REQ = 16'd1;

   localparam logic [1:0] OUT_OP_NONE  = 2'd0;
   localparam logic [1:0] OUT_OP_REQ   = 2'd1;
   localparam logic [1:0] OUT_OP_REPLY = 2'd2;

   localparam logic [MacW-1:0] BCAST_MAC = '1;

   localparam logic [CsrIdxW-1:0] CSR_OWN_MAC = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_OWN_IP  = 1'd1;

   typedef struct packed {
      logic            opcode;
      logic [31:0]     target_ip;
      logic [15:0]     rx_ethertype;
      logic [MacW-1:0] rx_dest_mac;
      logic [MacW-1:0] rx_src_mac;
      logic [15:0]     arp_operation;
      logic [MacW-1:0] arp_sender_mac;
      logic [31:0]     arp_sender_ip;
      logic [31:0]     arp_target_ip;
   } req_type;

   typedef struct packed {
      logic [2:0]      action;
      logic [MacW-1:0] out_dest_mac;
      logic [15:0]     out_ethertype;
      logic [1:0]      out_arp_operation;
      logic [MacW-1:0] out_arp_target_mac;
      logic [31:0]     out_arp_target_ip;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [SlotW-1:0] addr;
      logic [MacW-1:0]  data;
   } tbl_wr_type;

endpackage

// ===== rtl/arprr_table.sv =====
// MAC table: 256 x 48 memory with per-entry valid bits and write bypass.
// Depends on arprr_pkg.
module arprr_table import arprr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [SlotW-1:0] rd_addr,
   input  tbl_wr_type       wr,
   output logic [MacW-1:0]  rd_data
);

   logic [MacW-1:0]         mac_mem_ff [TableEntries];
   logic [TableEntries-1:0] valid_ff;
   logic [MacW-1:0]         rd_q_ff;
   logic                    rd_vld_ff;
   logic                    fwd_ff;
   logic                    fwd_in;
   logic [MacW-1:0]         fwd_data_ff;

   assign fwd_in = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mac_mem_ff[wr.addr] <= wr.data;
      end
      rd_q_ff     <= mac_mem_ff[rd_addr];
      fwd_data_ff <= wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_addr];
         fwd_ff    <= fwd_in;
      end
   end

   always_comb begin
      priority if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_vld_ff) begin
         rd_data = rd_q_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

// ===== rtl/arprr_decide.sv =====
// Per-beat decision: resolve, request, reply or deliver, and the table update.
// Depends on arprr_pkg.
module arprr_decide import arprr_pkg::*; (
   input  logic            item_valid,
   input  req_type         item,
   input  logic [MacW-1:0] entry,
   input  logic [MacW-1:0] own_mac,
   input  logic [7:0]      own_ip_lo,
   output rsp_type         result,
   output tbl_wr_type      wr
);

   logic known;
   logic target_match;

   assign known        = (entry != '0);
   assign target_match = (item.arp_target_ip[7:0] == own_ip_lo);

   always_comb begin
      result  = '0;
      wr.en   = 1'b0;
      wr.addr = item.arp_sender_ip[SlotW-1:0];
      wr.data = item.arp_sender_mac;
      if (item.opcode == OPC_TRANSMIT) begin
         if (!known) begin
            result.action            = ACT_SEND_REQ;
            result.out_dest_mac      = BCAST_MAC;
            result.out_ethertype     = ETH_ARP;
            result.out_arp_operation = OUT_OP_REQ;
            result.out_arp_target_ip = item.target_ip;
         end else begin
            result.action        = ACT_SEND_IP;
            result.out_dest_mac  = entry;
            result.out_ethertype = ETH_IPV4;
         end
      end else if (item.rx_ethertype == ETH_ARP) begin
         wr.en = item_valid && (known || target_match);
         if (target_match && (item.arp_operation == ARP_OPER_REQ)) begin
            result.action             = ACT_SEND_REPLY;
            result.out_dest_mac       = item.rx_src_mac;
            result.out_ethertype      = ETH_ARP;
            result.out_arp_operation  = OUT_OP_REPLY;
            result.out_arp_target_mac = item.arp_sender_mac;
            result.out_arp_target_ip  = item.arp_sender_ip;
         end
      end else if ((item.rx_ethertype == ETH_IPV4) && (item.rx_dest_mac == own_mac)) begin
         result.action        = ACT_DELIVER;
         result.out_dest_mac  = item.rx_dest_mac;
         result.out_ethertype = ETH_IPV4;
      end
   end

endmodule

// ===== rtl/arp_resolver_responder.sv =====
// Top level of the ARP resolver and responder: input stage, MAC table,
// decision logic and result register. Depends on arprr_pkg, arprr_table, arprr_decide.
//
//   channel  ports                              handshake
//   req      start, busy, req_data              start && !busy
//   rsp      rsp_strobe, rsp_data               one-cycle strobe, no stall
//   csr      csr_we, csr_index, csr_wdata       csr_we
//
// One beat per cycle; each taken request is registered in the input stage, then its result in the result register.
// The table read is registered in the accept cycle and the table write happens in
// the decision cycle; a write to the slot read by the next beat is bypassed.
// busy stays low. Reset clears the table valid bits, the stage valid flags and the own MAC and IP registers.
// The receiver cannot stall; results are never held.
module arp_resolver_responder import arprr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [MacW-1:0]    csr_wdata
);

   logic             item_valid_ff;
   req_type          item_ff;
   logic [MacW-1:0]  own_mac_ff;
   logic [7:0]       own_ip_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic [SlotW-1:0] rd_addr;
   logic [MacW-1:0]  entry;
   rsp_type          result;
   tbl_wr_type       wr;
   logic             accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign rd_addr = (req_data.opcode == OPC_TRANSMIT) ? req_data.target_ip[SlotW-1:0]
                                                      : req_data.arp_sender_ip[SlotW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         own_mac_ff    <= '0;
         own_ip_ff     <= '0;
      end else begin
         item_valid_ff <= accept;
         rsp_valid_ff  <= item_valid_ff;
         if (csr_we) begin
            unique case (csr_index)
               CSR_OWN_MAC: own_mac_ff <= csr_wdata;
               CSR_OWN_IP:  own_ip_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      rsp_ff <= result;
   end

   arprr_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (entry)
   );

   arprr_decide u_decide (
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .entry      (entry),
      .own_mac    (own_mac_ff),
      .own_ip_lo  (own_ip_ff),
      .result     (result),
      .wr         (wr)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted beat did not produce a result two cycles later");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(item_valid_ff))
      else $error("result strobe without a beat in the decision stage");

   a_wr_only_arp: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (item_valid_ff && item_ff.opcode == OPC_RECEIVE
                 && item_ff.rx_ethertype == ETH_ARP))
      else $error("table written by a beat that is not a received ARP frame");

   a_req_bcast: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.action == ACT_SEND_REQ) |->
         (rsp_data.out_dest_mac == BCAST_MAC && rsp_data.out_ethertype == ETH_ARP))
      else $error("ARP request not broadcast");

endmodule
